>>> rtl/button_gesture_classifier_macros.svh
// assertion helpers, sampled on the block clock and quiet during reset
`ifndef BUTTON_GESTURE_CLASSIFIER_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define BGC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BGC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bgc_pkg.sv
`default_nettype none

package bgc_pkg;

   localparam int unsigned MS_W        = 16;
   localparam int unsigned TALLY_W     = 8;
   localparam int unsigned CODE_W      = 3;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned MAX_EVENTS  = 3;

   localparam logic [MS_W-1:0] LONG_PRESS_RESET   = 16'd800;
   localparam logic [MS_W-1:0] MULTI_WINDOW_RESET = 16'd400;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LONG_PRESS_MS   = 8'd0,
      REG_MULTI_WINDOW_MS = 8'd1
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      EV_PRESS    = 3'd0,
      EV_RELEASE  = 3'd1,
      EV_REGULAR  = 3'd2,
      EV_LONG     = 3'd3,
      EV_LONG_END = 3'd4,
      EV_MULTI    = 3'd5
   } event_code_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [TALLY_W-1:0] count;
   } event_type;

   // events caused by one tick, in emission order
   typedef struct packed {
      logic [1:0]                      num;
      event_type [MAX_EVENTS-1:0]      ev;
   } event_list_type;

endpackage

`default_nettype wire

>>> rtl/bgc_if.sv
`default_nettype none

interface bgc_req_if import bgc_pkg::*; ();
   logic valid;
   logic ready;
   logic pressed_level;

   modport source (output valid, output pressed_level, input ready);
   modport sink   (input valid, input pressed_level, output ready);
endinterface

interface bgc_rsp_if import bgc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  event_code;
   logic [TALLY_W-1:0] click_count;
   logic               last_event;

   modport source (output valid, output event_code, output click_count,
                   output last_event, input ready);
   modport sink   (input valid, input event_code, input click_count,
                   input last_event, output ready);
endinterface

interface bgc_csr_if import bgc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [MS_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/bgc_core.sv
`default_nettype none

module bgc_core import bgc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   bgc_req_if.sink      req_bus,
   bgc_csr_if.sink      csr_bus,
   input  wire logic    buf_free,
   output logic         list_load,
   output event_list_type list_out
);

   logic               in_valid_ff, in_valid_in;
   logic               in_level_ff;
   logic [MS_W-1:0]    long_ms_ff, long_ms_in;
   logic [MS_W-1:0]    window_ms_ff, window_ms_in;
   logic               level_ff, level_in;
   logic [MS_W-1:0]    since_ff, since_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               fired_ff, fired_in;
   logic               active_ff, active_in;
   logic               window_ff, window_in;

   logic               take;
   logic [MS_W-1:0]    since_inc;
   logic [1:0]         slot;
   event_list_type     list;

   assign take          = in_valid_ff & buf_free;
   assign req_bus.ready = ~in_valid_ff | take;
   assign csr_bus.ready = 1'b1;
   assign list_load     = take;
   assign list_out      = list;

   always_comb begin
      in_valid_in = req_bus.valid | (in_valid_ff & ~take);
   end

   always_comb begin
      long_ms_in   = long_ms_ff;
      window_ms_in = window_ms_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_LONG_PRESS_MS:   long_ms_in   = csr_bus.data;
            REG_MULTI_WINDOW_MS: window_ms_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   // classification of the held tick against the current state
   always_comb begin
      since_inc = (since_ff == '1) ? since_ff : since_ff + 1'b1;
      level_in  = level_ff;
      since_in  = since_inc;
      tally_in  = tally_ff;
      fired_in  = fired_ff;
      active_in = active_ff;
      window_in = window_ff;
      list      = '0;
      slot      = 2'd0;

      if (in_level_ff != level_ff) begin
         level_in = in_level_ff;
         since_in = '0;
         if (in_level_ff) begin
            if (tally_ff != '1) begin
               tally_in = tally_ff + 1'b1;
            end
            fired_in  = 1'b0;
            window_in = 1'b0;
            list.ev[slot] = '{code: EV_PRESS, count: '0};
            slot = slot + 2'd1;
         end else begin
            list.ev[slot] = '{code: EV_RELEASE, count: '0};
            slot = slot + 2'd1;
            if (!fired_ff) begin
               list.ev[slot] = '{code: EV_REGULAR, count: '0};
               slot = slot + 2'd1;
            end
            priority if (!fired_ff && since_inc >= window_ms_ff) begin
               tally_in  = '0;
               window_in = 1'b0;
               list.ev[slot] = '{code: EV_MULTI, count: TALLY_W'(1)};
               slot = slot + 2'd1;
            end else if (fired_ff) begin
               tally_in  = '0;
               window_in = 1'b0;
            end else if (tally_ff != '0) begin
               window_in = 1'b1;
            end
            // an active long press always has fired, so at most three events here
            if (active_ff) begin
               active_in = 1'b0;
               if (slot != 2'd3) begin
                  list.ev[slot] = '{code: EV_LONG_END, count: '0};
                  slot = slot + 2'd1;
               end
            end
         end
      end else if (!in_level_ff && window_ff && since_inc >= window_ms_ff) begin
         window_in = 1'b0;
         tally_in  = '0;
         if (tally_ff != '0) begin
            list.ev[slot] = '{code: EV_MULTI, count: tally_ff};
            slot = slot + 2'd1;
         end
      end else if (in_level_ff && long_ms_ff != '0 && !fired_ff
                   && since_inc >= long_ms_ff) begin
         fired_in  = 1'b1;
         active_in = 1'b1;
         list.ev[slot] = '{code: EV_LONG, count: '0};
         slot = slot + 2'd1;
      end
      list.num = slot;
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_level_ff <= req_bus.pressed_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         long_ms_ff   <= LONG_PRESS_RESET;
         window_ms_ff <= MULTI_WINDOW_RESET;
         level_ff     <= 1'b0;
         since_ff     <= '0;
         tally_ff     <= '0;
         fired_ff     <= 1'b0;
         active_ff    <= 1'b0;
         window_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         long_ms_ff   <= long_ms_in;
         window_ms_ff <= window_ms_in;
         if (take) begin
            level_ff  <= level_in;
            since_ff  <= since_in;
            tally_ff  <= tally_in;
            fired_ff  <= fired_in;
            active_ff <= active_in;
            window_ff <= window_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/bgc_evbuf.sv
`default_nettype none

module bgc_evbuf import bgc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           list_load,
   input  wire event_list_type list_in,
   output logic                buf_free,
   bgc_rsp_if.source           rsp_bus
);

   event_list_type list_ff;
   logic [1:0]     num_ff, num_in;
   logic [1:0]     idx_ff, idx_in;
   logic           is_last;
   logic           rsp_fire;
   event_type      cur;

   assign cur      = list_ff.ev[idx_ff];
   assign is_last  = (idx_ff == num_ff - 2'd1);
   assign rsp_fire = rsp_bus.valid & rsp_bus.ready;
   assign buf_free = (num_ff == 2'd0) | (rsp_fire & is_last);

   assign rsp_bus.valid       = (num_ff != 2'd0);
   assign rsp_bus.event_code  = cur.code;
   assign rsp_bus.click_count = cur.count;
   assign rsp_bus.last_event  = is_last;

   always_comb begin
      num_in = num_ff;
      idx_in = idx_ff;
      if (rsp_fire) begin
         if (is_last) begin
            num_in = 2'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (list_load) begin
         num_in = list_in.num;
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (list_load) begin
         list_ff <= list_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         num_ff <= num_in;
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/button_gesture_classifier.sv
// Push-button gesture classifier: each request is one millisecond tick with the
// debounced level; responses are press, release, regular complete, long press,
// long press end and multi-press complete events, with last_event marking the
// final event of a tick. A tick is held in an input register, classified
// combinationally, and its up to three events are loaded into an event buffer
// that drives the response port one event per cycle while the port is ready;
// a tick passes through the input register and then the event buffer.
// A held tick is loaded only once the buffer is empty or its last event is
// taken, so the event buffer drain paces the ticks. The input register takes
// a new request while the buffer still offers events. Register writes take
// effect on the next cycle and are always accepted; index 0 is long_press_ms
// (zero disables long press), index 1 is multi_press_window_ms, others are
// ignored.
`default_nettype none

module button_gesture_classifier import bgc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   bgc_req_if.sink   req_bus,
   bgc_rsp_if.source rsp_bus,
   bgc_csr_if.sink   csr_bus
);

`include "button_gesture_classifier_macros.svh"

   logic           buf_free;
   logic           list_load;
   event_list_type list;
   logic           rsp_more;
   logic           rsp_plain;
   logic           rsp_long_end;

   bgc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .buf_free  (buf_free),
      .list_load (list_load),
      .list_out  (list)
   );

   bgc_evbuf u_evbuf (
      .clock     (clock),
      .reset     (reset),
      .list_load (list_load),
      .list_in   (list),
      .buf_free  (buf_free),
      .rsp_bus   (rsp_bus)
   );

   assign rsp_more     = rsp_bus.valid & rsp_bus.ready & ~rsp_bus.last_event;
   assign rsp_plain    = rsp_bus.valid & (rsp_bus.event_code != EV_MULTI);
   assign rsp_long_end = rsp_bus.valid & (rsp_bus.event_code == EV_LONG_END);

   // events of one tick follow each other without a gap
   `BGC_ASSERT_NEXT(a_tick_contiguous, rsp_more, rsp_bus.valid, "bgc: gap in tick")
   // only multi-press complete carries a count
   `BGC_ASSERT_NOW(a_count_only_multi, rsp_plain, rsp_bus.click_count == '0, "bgc: stray count")
   // long press end closes its tick
   `BGC_ASSERT_NOW(a_long_end_last, rsp_long_end, rsp_bus.last_event, "bgc: long end not last")

endmodule

`default_nettype wire
